>>> hw/rtl/glyph_row_pixel_writer_assert.svh
// ---------------------------------------------------------------------------
// glyph row pixel writer assertion macros
// concurrent checks clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef GLYPH_ROW_PIXEL_WRITER_ASSERT_SVH
`define GLYPH_ROW_PIXEL_WRITER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define GRPW_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grpw check failed");

// antecedent implies consequent in the next cycle
`define GRPW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grpw check failed");

`endif

>>> hw/rtl/grpw_pkg.sv
// ---------------------------------------------------------------------------
// grpw_pkg
// shared types, constants and color formatting for the glyph row writer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package grpw_pkg;

  // widest glyph row in pixels (8 to 16)
  localparam int GLYPH_MAX_W = 16;
  localparam int NARROW_W    = 8;
  localparam int CNT_W       = $clog2(GLYPH_MAX_W + 1);

  typedef logic [GLYPH_MAX_W-1:0] glyph_row_t;
  typedef logic [CNT_W-1:0]       pix_cnt_t;

  // pixel formats
  typedef enum logic [1:0] {
    FMT_BYTE  = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_WORD  = 2'd2,
    FMT_NONE  = 2'd3
  } pix_fmt_t;

  // register indexes
  typedef enum logic [2:0] {
    REG_FB_BASE    = 3'd0,
    REG_LINE_BYTES = 3'd1,
    REG_PIX_FMT    = 3'd2,
    REG_FG_COLOR   = 3'd3,
    REG_BG_COLOR   = 3'd4
  } reg_idx_t;

  // row base handed from the address unit to the pixel emitter
  typedef struct packed {
    logic        valid;
    logic [31:0] base;
  } grpw_row_t;

  // rgb888 to the configured pixel format, zero extended
  function automatic logic [31:0] fmt_color(input logic [1:0] fmt, input logic [23:0] rgb);
    logic [31:0] res;
    res = {8'd0, rgb};
    case (fmt)
      FMT_BYTE:   res = {24'd0, rgb[7:0]};
      FMT_RGB565: res = {16'd0, rgb[23:19], rgb[15:10], rgb[7:3]};
      default:    res = {8'd0, rgb};
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/grpw_mul.sv
// ---------------------------------------------------------------------------
// grpw_mul
// bit-serial row address unit: fb_base + (x << fmt) + y * line_bytes,
// one bit of y per cycle, skipping out once the remaining y bits are zero
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grpw_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [31:0]           fb_base,
  input  logic [14:0]           line_bytes,
  input  logic [1:0]            pix_fmt,
  input  logic [11:0]           pos_x,
  input  logic [11:0]           pos_y,
  input  logic                  pix_ready,
  output logic                  busy,
  output grpw_pkg::grpw_row_t   row
);

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t      state_r;
  logic [31:0] acc_r, acc_nxt;
  logic [31:0] mcand_r, mcand_nxt;
  logic [11:0] y_r, y_nxt;
  logic        done;

  assign done      = (state_r == ST_RUN) && (y_r == 12'd0);
  assign busy      = (state_r == ST_RUN);
  assign row.valid = done;
  assign row.base  = acc_r;

  // one shift-add step per cycle
  always_comb begin
    acc_nxt   = acc_r;
    mcand_nxt = mcand_r;
    y_nxt     = y_r;
    if (start) begin
      acc_nxt   = fb_base + (32'(pos_x) << pix_fmt);
      mcand_nxt = 32'(line_bytes);
      y_nxt     = pos_y;
    end else if (state_r == ST_RUN && y_r != 12'd0) begin
      if (y_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt = {mcand_r[30:0], 1'b0};
      y_nxt     = {1'b0, y_r[11:1]};
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    acc_r   <= acc_nxt;
    mcand_r <= mcand_nxt;
    y_r     <= y_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      case (state_r)
        ST_IDLE: if (start) state_r <= ST_RUN;
        ST_RUN:  if (done && pix_ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/grpw_pix.sv
// ---------------------------------------------------------------------------
// grpw_pix
// pixel emitter: shifts glyph bits out msb first, one pixel write per cycle,
// into an output register that holds while the receiver stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grpw_pix (
  input  logic                  clk,
  input  logic                  rst_n,
  input  grpw_pkg::grpw_row_t   row,
  input  logic [15:0]           row_bits,
  input  logic                  wide,
  input  logic [1:0]            pix_fmt,
  input  logic [23:0]           fg_color,
  input  logic [23:0]           bg_color,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           out_write_addr,
  output logic [31:0]           out_write_data,
  output logic [1:0]            out_write_size,
  output logic                  out_last_pixel
);

  grpw_pkg::glyph_row_t shift_r;
  grpw_pkg::pix_cnt_t   remain_r;
  logic [31:0]          addr_r;
  logic                 valid_r;
  logic [31:0]          waddr_r;
  logic [31:0]          wdata_r;
  logic [1:0]           wsize_r;
  logic                 last_r;
  logic                 adv;
  logic                 start;

  assign ready = (remain_r == '0);
  assign start = ready && row.valid;
  assign adv   = (remain_r != '0) && (!valid_r || !out_stall);

  assign out_valid      = valid_r;
  assign out_write_addr = waddr_r;
  assign out_write_data = wdata_r;
  assign out_write_size = wsize_r;
  assign out_last_pixel = last_r;

  // row load and per pixel shift
  always_ff @(posedge clk) begin
    if (start) begin
      addr_r  <= row.base;
      shift_r <= wide ? row_bits[grpw_pkg::GLYPH_MAX_W-1:0]
                      : grpw_pkg::glyph_row_t'(row_bits[grpw_pkg::NARROW_W-1:0])
                        << (grpw_pkg::GLYPH_MAX_W - grpw_pkg::NARROW_W);
    end else if (adv) begin
      addr_r  <= addr_r + (32'd1 << pix_fmt);
      shift_r <= shift_r << 1;
    end
    if (adv) begin
      waddr_r <= addr_r;
      wdata_r <= grpw_pkg::fmt_color(pix_fmt,
                   shift_r[grpw_pkg::GLYPH_MAX_W-1] ? fg_color : bg_color);
      wsize_r <= pix_fmt;
      last_r  <= (remain_r == grpw_pkg::pix_cnt_t'(1));
    end
    if (!rst_n) begin
      remain_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (start) begin
        remain_r <= wide ? grpw_pkg::pix_cnt_t'(grpw_pkg::GLYPH_MAX_W)
                         : grpw_pkg::pix_cnt_t'(grpw_pkg::NARROW_W);
      end else if (adv) begin
        remain_r <= remain_r - grpw_pkg::pix_cnt_t'(1);
      end
      if (adv) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/glyph_row_pixel_writer.sv
// ---------------------------------------------------------------------------
// glyph_row_pixel_writer
// turns one monochrome glyph row into one framebuffer write per pixel
// ---------------------------------------------------------------------------
// Usage: a request on the in_ channel carries one glyph row (pos_x, pos_y,
// row_bits, wide). Each row produces 8 or 16 requests on the out_ channel,
// leftmost pixel first, last_pixel set on the final one. Rows sent while
// pixel_format is 3 are taken and produce nothing.
// Address: the row address is built by a bit-serial shift-add over pos_y,
// one bit per cycle, ending once the remaining bits of pos_y are zero;
// the emitter loads the row once it is free, then registers the first write.
// Throughput: one pixel write per cycle while the receiver does not stall.
// The next row's address is built while the current row drains. in_stall
// stays high from accept until the row has been handed to the pixel
// emitter, which starts only after the previous row's pixels have all
// left its counter.
// Stall: a stalled out_ request holds its payload; the emitter pauses.
// Reset: synchronous, active low; registers return to their defaults
// (pixel_format four byte, fg_color 0x0000ff) and nothing is in flight.
// Registers sit on an APB-style port at byte address 4*index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "glyph_row_pixel_writer_assert.svh"

module glyph_row_pixel_writer (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // glyph rows
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [15:0] in_row_bits,
  input  logic        in_wide,
  // pixel writes
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_write_addr,
  output logic [31:0] out_write_data,
  output logic [1:0]  out_write_size,
  output logic        out_last_pixel
);

  logic [31:0]         fb_base_r;
  logic [14:0]         line_bytes_r;
  logic [1:0]          pix_fmt_r;
  logic [23:0]         fg_color_r;
  logic [23:0]         bg_color_r;
  logic [15:0]         row_bits_r;
  logic                wide_r;
  logic                in_take;
  logic                mul_start;
  logic                mul_busy;
  logic                pix_ready;
  logic                cfg_wr;
  grpw_pkg::reg_idx_t  cfg_idx;
  grpw_pkg::grpw_row_t row;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign cfg_idx   = grpw_pkg::reg_idx_t'(paddr[4:2]);
  assign in_stall  = mul_busy;
  assign in_take   = in_valid && !in_stall;
  assign mul_start = in_take && (pix_fmt_r != grpw_pkg::FMT_NONE);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_base_r    <= 32'd0;
      line_bytes_r <= 15'd0;
      pix_fmt_r    <= grpw_pkg::FMT_WORD;
      fg_color_r   <= 24'h0000ff;
      bg_color_r   <= 24'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        grpw_pkg::REG_FB_BASE:    fb_base_r    <= pwdata;
        grpw_pkg::REG_LINE_BYTES: line_bytes_r <= pwdata[14:0];
        grpw_pkg::REG_PIX_FMT:    pix_fmt_r    <= pwdata[1:0];
        grpw_pkg::REG_FG_COLOR:   fg_color_r   <= pwdata[23:0];
        grpw_pkg::REG_BG_COLOR:   bg_color_r   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (cfg_idx)
      grpw_pkg::REG_FB_BASE:    prdata = fb_base_r;
      grpw_pkg::REG_LINE_BYTES: prdata = 32'(line_bytes_r);
      grpw_pkg::REG_PIX_FMT:    prdata = 32'(pix_fmt_r);
      grpw_pkg::REG_FG_COLOR:   prdata = 32'(fg_color_r);
      grpw_pkg::REG_BG_COLOR:   prdata = 32'(bg_color_r);
      default:                  prdata = 32'd0;
    endcase
  end

  // glyph bits wait here while the row address is built
  always_ff @(posedge clk) begin
    if (mul_start) begin
      row_bits_r <= in_row_bits;
      wide_r     <= in_wide;
    end
  end

  grpw_mul u_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (mul_start),
    .fb_base    (fb_base_r),
    .line_bytes (line_bytes_r),
    .pix_fmt    (pix_fmt_r),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .pix_ready  (pix_ready),
    .busy       (mul_busy),
    .row        (row)
  );

  grpw_pix u_pix (
    .clk            (clk),
    .rst_n          (rst_n),
    .row            (row),
    .row_bits       (row_bits_r),
    .wide           (wide_r),
    .pix_fmt        (pix_fmt_r),
    .fg_color       (fg_color_r),
    .bg_color       (bg_color_r),
    .ready          (pix_ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_write_size (out_write_size),
    .out_last_pixel (out_last_pixel)
  );

  // a row that will produce writes blocks further rows until handed off
  `GRPW_ASSERT_NEXT(a_row_blocks, mul_start, in_stall)
  // a taken write that is not the last one is followed by another
  `GRPW_ASSERT_NEXT(a_row_continues, out_valid && !out_stall && !out_last_pixel, out_valid)
  // the address unit only hands off to an idle emitter
  `GRPW_ASSERT_NEXT(a_handoff_starts, row.valid && pix_ready, !pix_ready)

endmodule

>>> tb/sv/grpw_checker.sv
// ---------------------------------------------------------------------------
// grpw_checker
// watches the register port and both request channels of the glyph row
// writer, predicts the pixel writes of each accepted row and compares them
// in order with the writes the block hands out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grpw_checker
  import grpw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // glyph rows
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [11:0] in_pos_x,
  input  logic [11:0] in_pos_y,
  input  logic [15:0] in_row_bits,
  input  logic        in_wide,
  // pixel writes
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_write_addr,
  input  logic [31:0] out_write_data,
  input  logic [1:0]  out_write_size,
  input  logic        out_last_pixel,
  // status for the test top
  output int          fail_count,
  output int          pending,
  output int          pixels_checked
);

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic [1:0]  size;
    logic        last;
  } pixel_write_t;

  pixel_write_t expected_writes[$];

  // shadow of the block's registers
  logic [31:0] fb_base_q;
  logic [14:0] line_bytes_q;
  logic [1:0]  pix_fmt_q;
  logic [23:0] fg_rgb_q;
  logic [23:0] bg_rgb_q;

  initial begin
    fail_count     = 0;
    pending        = 0;
    pixels_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("grpw_checker: %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // rgb888 in the current pixel format
  function automatic logic [31:0] to_pixel(input logic [23:0] rgb);
    logic [31:0] px;
    case (pix_fmt_q)
      FMT_BYTE:   px = {24'h0, rgb[7:0]};
      FMT_RGB565: px = {16'h0, rgb[23:19], rgb[15:10], rgb[7:3]};
      default:    px = {8'h0, rgb};
    endcase
    return px;
  endfunction

  // queue one write per pixel of the row, leftmost first
  task automatic expand_row(input logic [11:0] x, input logic [11:0] y,
                            input logic [15:0] bits, input logic wide);
    pixel_write_t wr;
    int           width;
    logic [31:0]  row_base;
    logic [31:0]  fg_px;
    logic [31:0]  bg_px;
    if (pix_fmt_q == FMT_NONE) return;
    width    = wide ? GLYPH_MAX_W : NARROW_W;
    row_base = fb_base_q + 32'(y) * 32'(line_bytes_q);
    fg_px    = to_pixel(fg_rgb_q);
    bg_px    = to_pixel(bg_rgb_q);
    for (int col = 0; col < width; col++) begin
      wr.addr = row_base + ((32'(x) + 32'(col)) << pix_fmt_q);
      wr.data = bits[width-1-col] ? fg_px : bg_px;
      wr.size = pix_fmt_q;
      wr.last = (col == width - 1);
      expected_writes.push_back(wr);
    end
  endtask

  task automatic check_write();
    pixel_write_t want;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write addr %08h data %08h",
                                out_write_addr, out_write_data));
      return;
    end
    want = expected_writes.pop_front();
    pixels_checked++;
    if (out_write_addr !== want.addr)
      report_mismatch($sformatf("write_addr %08h, want %08h", out_write_addr, want.addr));
    if (out_write_data !== want.data)
      report_mismatch($sformatf("write_data %08h at %08h, want %08h",
                                out_write_data, want.addr, want.data));
    if (out_write_size !== want.size)
      report_mismatch($sformatf("write_size %0d at %08h, want %0d",
                                out_write_size, want.addr, want.size));
    if (out_last_pixel !== want.last)
      report_mismatch($sformatf("last_pixel %0b at %08h, want %0b",
                                out_last_pixel, want.addr, want.last));
  endtask

  // everything sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      fb_base_q    = 32'h0;
      line_bytes_q = 15'h0;
      pix_fmt_q    = FMT_WORD;
      fg_rgb_q     = 24'h0000ff;
      bg_rgb_q     = 24'h0;
      expected_writes.delete();
    end else begin
      if (in_valid && !in_stall)
        expand_row(in_pos_x, in_pos_y, in_row_bits, in_wide);
      if (out_valid && !out_stall)
        check_write();
      // register write; unknown indexes leave everything as it is
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_FB_BASE:    fb_base_q    = pwdata;
          REG_LINE_BYTES: line_bytes_q = pwdata[14:0];
          REG_PIX_FMT:    pix_fmt_q    = pwdata[1:0];
          REG_FG_COLOR:   fg_rgb_q     = pwdata[23:0];
          REG_BG_COLOR:   bg_rgb_q     = pwdata[23:0];
          default: ;
        endcase
      end
    end
    pending = expected_writes.size();
  end

endmodule

>>> tb/sv/tb_glyph_row_pixel_writer.sv
// ---------------------------------------------------------------------------
// tb_glyph_row_pixel_writer
// drives glyph rows and register writes into the glyph row pixel writer,
// stalls the pixel write channel at random and lets grpw_checker judge
// every write; directed corner rows first, then random rows over several
// register settings and three idle/stall mixes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_glyph_row_pixel_writer;
  import grpw_pkg::*;

  // register index with no register behind it
  localparam logic [2:0] REG_SPARE = 3'd6;
  // rows can yield nothing, so allow address build plus one wide row
  localparam int QUIET_CYCLES     = 40;
  localparam int ROWS_PER_SETTING = 34;
  localparam int SETTINGS_PER_MIX = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [11:0] in_pos_x = '0;
  logic [11:0] in_pos_y = '0;
  logic [15:0] in_row_bits = '0;
  logic        in_wide = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_write_addr;
  logic [31:0] out_write_data;
  logic [1:0]  out_write_size;
  logic        out_last_pixel;

  int fail_count;
  int pending;
  int pixels_checked;
  int rows_sent = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  glyph_row_pixel_writer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_row_bits    (in_row_bits),
    .in_wide        (in_wide),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_write_size (out_write_size),
    .out_last_pixel (out_last_pixel)
  );

  grpw_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_row_bits    (in_row_bits),
    .in_wide        (in_wide),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_write_size (out_write_size),
    .out_last_pixel (out_last_pixel),
    .fail_count     (fail_count),
    .pending        (pending),
    .pixels_checked (pixels_checked)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // run limit
  initial begin
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

  // register write with a setup and an access phase, done once pready is seen
  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // hold off until every write is out and the block has gone quiet
  task automatic wait_quiet();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  task automatic load_config(input logic [31:0] base, input logic [14:0] line,
                             input pix_fmt_t fmt, input logic [23:0] fg,
                             input logic [23:0] bg);
    wait_quiet();
    write_register(REG_FB_BASE, base);
    write_register(REG_LINE_BYTES, 32'(line));
    write_register(REG_PIX_FMT, 32'(fmt));
    write_register(REG_FG_COLOR, 32'(fg));
    write_register(REG_BG_COLOR, 32'(bg));
  endtask

  // one row request, with random idle cycles ahead of it
  task automatic send_row(input logic [11:0] x, input logic [11:0] y,
                          input logic [15:0] bits, input logic wide);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid    = 1'b0;
      in_pos_x    = 12'($urandom);
      in_pos_y    = 12'($urandom);
      in_row_bits = 16'($urandom);
      in_wide     = 1'($urandom);
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_pos_x    = x;
    in_pos_y    = y;
    in_row_bits = bits;
    in_wide     = wide;
    do @(posedge clk); while (in_stall);
    rows_sent++;
    @(negedge clk);
  endtask

  // zero, all ones or random within the mask
  function automatic logic [31:0] pick_value(input logic [31:0] mask);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0:       v = 32'h0;
      1:       v = mask;
      default: v = $urandom & mask;
    endcase
    return v;
  endfunction

  task automatic random_config();
    int       r;
    pix_fmt_t fmt;
    r   = $urandom_range(0, 9);
    fmt = (r == 9) ? FMT_NONE : pix_fmt_t'(r % 3);
    load_config(pick_value(32'hffff_ffff), 15'(pick_value(32'h7fff)), fmt,
                24'(pick_value(32'hff_ffff)), 24'(pick_value(32'hff_ffff)));
  endtask

  initial begin
    // hold reset low, then release it
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    snd_idle_pct  = 25;
    rcv_stall_pct = 65;

    // reset defaults: four byte pixels, blue on black
    send_row(12'd0, 12'd0, 16'hffff, 1'b1);
    send_row(12'd4095, 12'd4095, 16'h0000, 1'b0);
    send_row(12'd4095, 12'd0, 16'h8001, 1'b1);

    // address wrap past 2^32, bits above a narrow row ignored
    load_config(32'hffff_fff0, 15'd16384, FMT_WORD, 24'hffffff, 24'h000000);
    send_row(12'd4095, 12'd4095, 16'ha5c3, 1'b1);
    send_row(12'd0, 12'd4095, 16'hff00, 1'b0);
    send_row(12'd1, 12'd1, 16'h00ff, 1'b0);

    // rgb565 with the widest line field
    load_config(32'h0000_1000, 15'h7fff, FMT_RGB565, 24'hffffff, 24'h123456);
    send_row(12'd2048, 12'd4095, 16'h5555, 1'b1);
    send_row(12'd0, 12'd0, 16'haaaa, 1'b1);
    send_row(12'd4094, 12'd1, 16'h7f80, 1'b0);

    // one byte pixels
    load_config(32'h8000_0000, 15'd640, FMT_BYTE, 24'habcdef, 24'hffff00);
    send_row(12'd4095, 12'd4095, 16'hffff, 1'b1);
    send_row(12'd7, 12'd3, 16'h0f3c, 1'b0);
    send_row(12'd100, 12'd200, 16'h1234, 1'b1);

    // unsupported format takes rows and writes nothing
    load_config(32'h0, 15'd1024, FMT_NONE, 24'h00ff00, 24'h0000ff);
    send_row(12'd5, 12'd4095, 16'hffff, 1'b1);
    send_row(12'd9, 12'd17, 16'h00f0, 1'b0);

    // write to a missing register must change nothing
    wait_quiet();
    write_register(REG_SPARE, 32'hffff_ffff);
    write_register(REG_PIX_FMT, 32'(FMT_WORD));
    send_row(12'd0, 12'd3, 16'h8000, 1'b1);
    send_row(12'd0, 12'd3, 16'h0080, 1'b0);

    // random rows over three idle/stall mixes
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          snd_idle_pct  = 25;
          rcv_stall_pct = 65;
        end
        1: begin
          snd_idle_pct  = 65;
          rcv_stall_pct = 25;
        end
        default: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
      endcase
      for (int s = 0; s < SETTINGS_PER_MIX; s++) begin
        random_config();
        for (int n = 0; n < ROWS_PER_SETTING; n++) begin
          // sender waits for the block to drain once per setting
          if (n == ROWS_PER_SETTING / 2) begin
            in_valid = 1'b0;
            while (pending != 0) @(negedge clk);
          end
          send_row(12'($urandom), 12'($urandom), 16'($urandom), 1'($urandom));
        end
      end
    end

    // drain and let trailing writes show up
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);

    $display("summary: %0d glyph rows sent, %0d pixel writes checked",
             rows_sent, pixels_checked);
    $display("summary: all pixel formats incl. unsupported, narrow and wide rows, %s",
             "address wrap, three idle/stall mixes");
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/grpw_pkg.sv
hw/rtl/grpw_mul.sv
hw/rtl/grpw_pix.sv
hw/rtl/glyph_row_pixel_writer.sv
tb/sv/grpw_checker.sv
tb/sv/tb_glyph_row_pixel_writer.sv
